>>> hw/rtl/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, entity table and control store for the entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam int ENT_COUNT    = 7;
  localparam int ENT_MAX_HELD = 5;
  localparam int ENT_MAX_LEN  = 6;

  localparam logic [7:0] CHR_AMP   = 8'h26;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_NONE  = 8'h00;

  localparam logic [0:ENT_MAX_LEN-1][7:0] ENT_TEXT [ENT_COUNT] = '{
    {"&amp;", 8'h00},
    {"&lt;", 16'h0000},
    {"&gt;", 16'h0000},
    "&quot;",
    {"&#39;", 8'h00},
    "&apos;",
    "&nbsp;"
  };

  localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{
    3'd5, 3'd4, 3'd4, 3'd6, 3'd5, 3'd6, 3'd6
  };

  localparam logic [7:0] ENT_VAL [ENT_COUNT] = '{
    8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h27, 8'h20
  };

  typedef struct packed {
    logic       full;
    logic       prefix;
    logic [7:0] value;
  } match_t;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_MATCH,
    OP_FEED,
    OP_FRESH,
    OP_EOLCHK,
    OP_MARK,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    SRC_CHR,
    SRC_ENT,
    SRC_BUF
  } src_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_MATCH    = 4'd1;
  localparam step_t STEP_FEED_ENT = 4'd2;
  localparam step_t STEP_FLUSH    = 4'd3;
  localparam step_t STEP_FRESH    = 4'd4;
  localparam step_t STEP_EOL      = 4'd5;
  localparam step_t STEP_EFLUSH   = 4'd6;
  localparam step_t STEP_MARK     = 4'd7;
  localparam step_t STEP_DONE     = 4'd8;

  typedef struct packed {
    op_t   op;
    src_t  src;
    step_t nxt;
    step_t jmp_a;
    step_t jmp_b;
  } uword_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CHR_SPACE) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic uword_t ucode(step_t s);
    uword_t w;
    unique case (s)
      STEP_IDLE:     w = '{OP_ACCEPT, SRC_CHR, STEP_MATCH, STEP_FRESH, STEP_IDLE};
      STEP_MATCH:    w = '{OP_MATCH,  SRC_CHR, STEP_FLUSH, STEP_FEED_ENT, STEP_EOL};
      STEP_FEED_ENT: w = '{OP_FEED,   SRC_ENT, STEP_EOL, STEP_IDLE, STEP_IDLE};
      STEP_FLUSH:    w = '{OP_FEED,   SRC_BUF, STEP_FRESH, STEP_IDLE, STEP_IDLE};
      STEP_FRESH:    w = '{OP_FRESH,  SRC_CHR, STEP_EOL, STEP_IDLE, STEP_IDLE};
      STEP_EOL:      w = '{OP_EOLCHK, SRC_CHR, STEP_DONE, STEP_EFLUSH, STEP_MARK};
      STEP_EFLUSH:   w = '{OP_FEED,   SRC_BUF, STEP_MARK, STEP_IDLE, STEP_IDLE};
      STEP_MARK:     w = '{OP_MARK,   SRC_CHR, STEP_DONE, STEP_IDLE, STEP_IDLE};
      STEP_DONE:     w = '{OP_DONE,   SRC_CHR, STEP_IDLE, STEP_IDLE, STEP_IDLE};
      default:       w = '{OP_DONE,   SRC_CHR, STEP_IDLE, STEP_IDLE, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/hed_match.sv
// ----------------------------------------------------------------------------
// hed_match
// Compares the held partial entity plus the new byte against the entity table.
// ----------------------------------------------------------------------------
module hed_match (
  input  logic [hed_pkg::ENT_MAX_HELD-1:0][7:0] held_bytes,
  input  logic [2:0]                            held_len,
  input  logic [7:0]                            new_byte,
  output hed_pkg::match_t                       result
);

  always_comb begin
    logic [0:hed_pkg::ENT_MAX_LEN-1][7:0] cand;
    logic [2:0] n;
    logic       ok;
    logic       full;
    logic       pfx;
    logic [7:0] value;

    n     = held_len + 3'd1;
    full  = 1'b0;
    pfx   = 1'b0;
    value = '0;
    cand[hed_pkg::ENT_MAX_LEN-1] = new_byte;
    for (int j = 0; j < hed_pkg::ENT_MAX_HELD; j++) begin
      cand[j] = (3'(j) < held_len) ? held_bytes[j] : new_byte;
    end
    for (int k = 0; k < hed_pkg::ENT_COUNT; k++) begin
      ok = (n <= hed_pkg::ENT_LEN[k]);
      for (int j = 0; j < hed_pkg::ENT_MAX_LEN; j++) begin
        if (3'(j) < n && cand[j] != hed_pkg::ENT_TEXT[k][j]) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        if (n == hed_pkg::ENT_LEN[k]) begin
          full  = 1'b1;
          value = value | hed_pkg::ENT_VAL[k];
        end else begin
          pfx = 1'b1;
        end
      end
    end
    result.full   = full;
    result.prefix = pfx && !full && (n <= 3'(hed_pkg::ENT_MAX_HELD));
    result.value  = value;
  end

endmodule

>>> hw/rtl/html_entity_decode_ws_collapse.sv
// ----------------------------------------------------------------------------
// html_entity_decode_ws_collapse
// Streaming entity decoder with whitespace collapsing, run by a microcoded
// step sequencer.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_stall   in_byte, in_end_of_line
//   out      out_valid / out_stall out_byte, out_byte_valid, out_line_end,
//                                  out_run_last
//
// One transaction is handled at a time: accept, decode, line-end check and
// release of the last result, each a sequencer step. Decode has steps for a
// match against a held partial entity and for starting a new entity, and it
// repeats a feed step per byte passed to the collapser and per pending space
// sent; a line end adds its flush and a marker step. Each result waits in a
// holding slot until the next one or the release, so that the run-last flag
// of the last one is known. Output stall only holds the sequencer when a new
// result or the release finds both the holding slot and the output register
// full. Reset is synchronous and active low and needs no clearing pass.
// ----------------------------------------------------------------------------
module html_entity_decode_ws_collapse (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_line_end,
  output logic       out_run_last
);

  hed_pkg::step_t  upc_r, upc_nxt;
  hed_pkg::uword_t uw;
  hed_pkg::match_t mres;

  logic [7:0] chr_r, chr_nxt;
  logic       eol_r, eol_nxt;
  logic [hed_pkg::ENT_MAX_HELD-1:0][7:0] held_r, held_nxt;
  logic [2:0] len_r, len_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] ent_val_r, ent_val_nxt;
  logic       lws_r, lws_nxt;
  logic       sp_r, sp_nxt;

  logic       hold_v_r, hold_v_nxt;
  logic [7:0] hold_byte_r, hold_byte_nxt;
  logic       hold_bv_r, hold_bv_nxt;
  logic       hold_le_r, hold_le_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_bv_r, out_bv_nxt;
  logic       out_le_r, out_le_nxt;
  logic       out_last_r, out_last_nxt;

  logic       out_free;
  logic       emit_ok;
  logic       emit_req;
  logic [7:0] emit_byte;
  logic       emit_bv;
  logic       emit_le;
  logic       out_load;
  logic       load_last;
  logic [7:0] feed_byte;
  logic       feed_go;
  logic       feed_done;

  assign uw = hed_pkg::ucode(upc_r);

  hed_match u_match (
    .held_bytes (held_r),
    .held_len   (len_r),
    .new_byte   (chr_r),
    .result     (mres)
  );

  assign in_stall       = (uw.op != hed_pkg::OP_ACCEPT);
  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_line_end   = out_le_r;
  assign out_run_last   = out_last_r;

  assign out_free = !out_valid_r || !out_stall;
  assign emit_ok  = !hold_v_r || out_free;

  always_comb begin
    case (uw.src)
      hed_pkg::SRC_ENT: feed_byte = ent_val_r;
      hed_pkg::SRC_BUF: feed_byte = held_r[idx_r];
      default:          feed_byte = chr_r;
    endcase
  end

  always_comb begin
    upc_nxt       = upc_r;
    chr_nxt       = chr_r;
    eol_nxt       = eol_r;
    held_nxt      = held_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    ent_val_nxt   = ent_val_r;
    lws_nxt       = lws_r;
    sp_nxt        = sp_r;
    hold_v_nxt    = hold_v_r;
    hold_byte_nxt = hold_byte_r;
    hold_bv_nxt   = hold_bv_r;
    hold_le_nxt   = hold_le_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_le_nxt    = out_le_r;
    out_last_nxt  = out_last_r;
    emit_req      = 1'b0;
    emit_byte     = feed_byte;
    emit_bv       = 1'b1;
    emit_le       = 1'b0;
    out_load      = 1'b0;
    load_last     = 1'b0;
    feed_done     = 1'b0;

    feed_go = (uw.op == hed_pkg::OP_FEED) ||
              (uw.op == hed_pkg::OP_FRESH && chr_r != hed_pkg::CHR_AMP);

    if (feed_go) begin
      if (hed_pkg::is_ws(feed_byte)) begin
        if (!lws_r) begin
          sp_nxt  = 1'b1;
          lws_nxt = 1'b1;
        end
        feed_done = 1'b1;
      end else if (sp_r) begin
        emit_req  = 1'b1;
        emit_byte = hed_pkg::CHR_SPACE;
        if (emit_ok) begin
          sp_nxt = 1'b0;
        end
      end else begin
        emit_req = 1'b1;
        if (emit_ok) begin
          lws_nxt   = 1'b0;
          feed_done = 1'b1;
        end
      end
    end

    unique case (uw.op)
      hed_pkg::OP_ACCEPT: begin
        if (in_valid) begin
          chr_nxt = in_byte;
          eol_nxt = in_end_of_line;
          upc_nxt = (len_r != 3'd0) ? uw.nxt : uw.jmp_a;
        end
      end
      hed_pkg::OP_MATCH: begin
        if (mres.full) begin
          ent_val_nxt = mres.value;
          len_nxt     = 3'd0;
          upc_nxt     = uw.jmp_a;
        end else if (mres.prefix) begin
          held_nxt[len_r] = chr_r;
          len_nxt         = len_r + 3'd1;
          upc_nxt         = uw.jmp_b;
        end else begin
          upc_nxt = uw.nxt;
        end
      end
      hed_pkg::OP_FEED: begin
        if (feed_done) begin
          if (uw.src == hed_pkg::SRC_BUF && idx_r != len_r - 3'd1) begin
            idx_nxt = idx_r + 3'd1;
          end else begin
            idx_nxt = 3'd0;
            if (uw.src == hed_pkg::SRC_BUF) begin
              len_nxt = 3'd0;
            end
            upc_nxt = uw.nxt;
          end
        end
      end
      hed_pkg::OP_FRESH: begin
        if (chr_r == hed_pkg::CHR_AMP) begin
          held_nxt[0] = chr_r;
          len_nxt     = 3'd1;
          upc_nxt     = uw.nxt;
        end else if (feed_done) begin
          upc_nxt = uw.nxt;
        end
      end
      hed_pkg::OP_EOLCHK: begin
        if (!eol_r) begin
          upc_nxt = uw.nxt;
        end else if (len_r != 3'd0) begin
          upc_nxt = uw.jmp_a;
        end else begin
          upc_nxt = uw.jmp_b;
        end
      end
      hed_pkg::OP_MARK: begin
        emit_req  = 1'b1;
        emit_byte = hed_pkg::CHR_NONE;
        emit_bv   = 1'b0;
        emit_le   = 1'b1;
        if (emit_ok) begin
          sp_nxt  = 1'b0;
          lws_nxt = 1'b1;
          upc_nxt = uw.nxt;
        end
      end
      hed_pkg::OP_DONE: begin
        if (!hold_v_r) begin
          upc_nxt = uw.nxt;
        end else if (out_free) begin
          out_load   = 1'b1;
          load_last  = 1'b1;
          hold_v_nxt = 1'b0;
          upc_nxt    = uw.nxt;
        end
      end
      default: begin
        upc_nxt = hed_pkg::STEP_IDLE;
      end
    endcase

    if (emit_req && emit_ok) begin
      if (hold_v_r) begin
        out_load = 1'b1;
      end
      hold_v_nxt    = 1'b1;
      hold_byte_nxt = emit_byte;
      hold_bv_nxt   = emit_bv;
      hold_le_nxt   = emit_le;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = hold_byte_r;
      out_bv_nxt    = hold_bv_r;
      out_le_nxt    = hold_le_r;
      out_last_nxt  = load_last;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= hed_pkg::STEP_IDLE;
      len_r       <= 3'd0;
      idx_r       <= 3'd0;
      lws_r       <= 1'b1;
      sp_r        <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      lws_r       <= lws_nxt;
      sp_r        <= sp_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chr_r       <= chr_nxt;
    eol_r       <= eol_nxt;
    held_r      <= held_nxt;
    ent_val_r   <= ent_val_nxt;
    hold_byte_r <= hold_byte_nxt;
    hold_bv_r   <= hold_bv_nxt;
    hold_le_r   <= hold_le_nxt;
    out_byte_r  <= out_byte_nxt;
    out_bv_r    <= out_bv_nxt;
    out_le_r    <= out_le_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

>>> bench/entity_decode_checker.sv
// ----------------------------------------------------------------------------
// entity_decode_checker
// Watches both channels of the entity decoder and checks every result.
// Each accepted input transaction is decoded by a local model of the entity
// matcher and whitespace collapser, and the results it produces are queued.
// Each accepted output transaction is compared field by field with the
// oldest queued result. The failure count and the number of results still
// awaited are handed to the bench top.
// ----------------------------------------------------------------------------
module entity_decode_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_line,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic       out_line_end,
  input  logic       out_run_last,
  output int         fail_count,
  output int         expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTITIES = 7;
  localparam int MAX_HELD     = 5;
  localparam int MAX_RESULTS  = 8;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] AMP_CHAR   = 8'h26;
  localparam logic [7:0] NULL_CHAR  = 8'h00;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       line_end;
    logic       run_last;
  } text_result_t;

  string entity_text [NUM_ENTITIES] = '{
    "&amp;", "&lt;", "&gt;", "&quot;", "&#39;", "&apos;", "&nbsp;"
  };
  logic [7:0] entity_char [NUM_ENTITIES] = '{
    8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h27, 8'h20
  };

  logic [7:0]   held_bytes [MAX_HELD];
  int           held_len;
  logic         after_space;
  logic         space_pending;
  text_result_t item_results [$];
  text_result_t decoded_q [$];
  int           mismatches;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == SPACE_CHAR) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  task automatic put_result(input logic [7:0] b, input logic vld, input logic le);
    text_result_t r;
    r.data       = b;
    r.data_valid = vld;
    r.line_end   = le;
    r.run_last   = 1'b0;
    if (item_results.size() < MAX_RESULTS) item_results.push_back(r);
  endtask

  task automatic collapse_byte(input logic [7:0] b);
    if (is_blank(b)) begin
      if (!after_space) begin
        space_pending = 1'b1;
        after_space   = 1'b1;
      end
    end else begin
      if (space_pending) begin
        put_result(SPACE_CHAR, 1'b1, 1'b0);
        space_pending = 1'b0;
      end
      put_result(b, 1'b1, 1'b0);
      after_space = 1'b0;
    end
  endtask

  task automatic start_fresh(input logic [7:0] b);
    if (b == AMP_CHAR) begin
      held_bytes[0] = b;
      held_len      = 1;
    end else begin
      collapse_byte(b);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [7:0] cand [MAX_HELD + 1];
    int         n;
    logic       prefix_seen;
    logic       same;
    if (held_len == 0) begin
      start_fresh(b);
      return;
    end
    n = held_len + 1;
    for (int i = 0; i < held_len; i++) cand[i] = held_bytes[i];
    cand[n - 1] = b;
    prefix_seen = 1'b0;
    for (int k = 0; k < NUM_ENTITIES; k++) begin
      if (n <= entity_text[k].len()) begin
        same = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (cand[i] != 8'(entity_text[k][i])) same = 1'b0;
        end
        if (same) begin
          if (n == entity_text[k].len()) begin
            held_len = 0;
            collapse_byte(entity_char[k]);
            return;
          end
          prefix_seen = 1'b1;
        end
      end
    end
    if (prefix_seen && n <= MAX_HELD) begin
      held_bytes[n - 1] = b;
      held_len          = n;
      return;
    end
    // The held bytes are no entity: send them literally, then rescan the new byte.
    for (int i = 0; i < held_len; i++) collapse_byte(held_bytes[i]);
    held_len = 0;
    start_fresh(b);
  endtask

  task automatic decode_item(input logic [7:0] b, input logic eol);
    text_result_t r;
    item_results.delete();
    decode_byte(b);
    if (eol) begin
      for (int i = 0; i < held_len; i++) collapse_byte(held_bytes[i]);
      held_len      = 0;
      space_pending = 1'b0;
      put_result(NULL_CHAR, 1'b0, 1'b1);
      after_space   = 1'b1;
    end
    if (item_results.size() > 0) begin
      r          = item_results.pop_back();
      r.run_last = 1'b1;
      item_results.push_back(r);
    end
    foreach (item_results[i]) decoded_q.push_back(item_results[i]);
  endtask

  always @(posedge clk) begin : track
    text_result_t want;
    if (!rst_n) begin
      foreach (held_bytes[i]) held_bytes[i] = NULL_CHAR;
      held_len      = 0;
      after_space   = 1'b1;
      space_pending = 1'b0;
      decoded_q.delete();
      mismatches    = 0;
    end else begin
      if (in_valid && !in_stall) decode_item(in_byte, in_end_of_line);
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected output transaction: out_byte %02h", out_byte);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
            mismatches++;
          end
          if (out_byte_valid !== want.data_valid) begin
            $error("out_byte_valid: expected %0b, actual %0b", want.data_valid,
                   out_byte_valid);
            mismatches++;
          end
          if (out_line_end !== want.line_end) begin
            $error("out_line_end: expected %0b, actual %0b", want.line_end, out_line_end);
            mismatches++;
          end
          if (out_run_last !== want.run_last) begin
            $error("out_run_last: expected %0b, actual %0b", want.run_last, out_run_last);
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    expected_left <= decoded_q.size();
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the streaming entity decoder with whitespace collapsing.
// A short directed set of lines covers the whitespace set, the zero and
// all-ones bytes, entities, a mismatch rescan with the largest result count,
// a partial entity cut off by the line end and a line with no text. Random
// lines of letters, whitespace, whole and broken entities and arbitrary bytes
// follow. The sender runs in bursts with random gaps, the receiver stalls in
// changing patterns, and a separate checker compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 290;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 6;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eol;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_line = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_line_end;
  logic       out_run_last;
  int         fail_count;
  int         expected_left;

  stall_mode_e stall_mode = STALL_NONE;
  int          stall_phase_left = 0;
  text_item_t  line_items [$];

  string entity_names [7] = '{
    "&amp;", "&lt;", "&gt;", "&quot;", "&#39;", "&apos;", "&nbsp;"
  };

  html_entity_decode_ws_collapse i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_end_of_line (in_end_of_line),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_line_end   (out_line_end),
    .out_run_last   (out_run_last)
  );

  entity_decode_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_end_of_line (in_end_of_line),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_line_end   (out_line_end),
    .out_run_last   (out_run_last),
    .fail_count     (fail_count),
    .expected_left  (expected_left)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode       <= stall_mode_e'($urandom_range(0, 3));
      stall_phase_left <= $urandom_range(10, 80);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
      default:     out_stall <= ~out_stall;
    endcase
  end

  task automatic add_byte(input logic [7:0] b, input logic eol);
    text_item_t it;
    it.data = b;
    it.eol  = eol;
    line_items.push_back(it);
  endtask

  task automatic add_text(input string s, input logic eol_last);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(8'(s[i]), eol_last && (i == s.len() - 1));
    end
  endtask

  task automatic send_item(input text_item_t it);
    in_valid       <= 1'b1;
    in_byte        <= it.data;
    in_end_of_line <= it.eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("[html_entity_decode_ws_collapse] ERROR");
    $finish;
  end

  initial begin : stimulus
    int         directed_count;
    int         pause_at;
    int         burst_left;
    int         gap;
    int         roll;
    int         len;
    int         k;
    text_item_t it;

    add_byte(8'h20, 1'b0);
    add_byte(8'h09, 1'b0);
    add_text("&lt;", 1'b0);
    add_byte(8'h0A, 1'b0);
    add_byte(8'h0B, 1'b0);
    add_byte(8'h0D, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_text("a &quot&", 1'b1);
    add_text("x&nbsp;", 1'b1);
    add_text("&g", 1'b1);
    add_byte(8'h0C, 1'b1);
    directed_count = line_items.size();

    while (line_items.size() < directed_count + RANDOM_ITEMS) begin
      len = $urandom_range(1, 16);
      for (int t = 0; t < len; t++) begin
        roll = $urandom_range(0, 99);
        k    = $urandom_range(0, 6);
        if (roll < 35) begin
          add_byte(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
        end else if (roll < 50) begin
          k = $urandom_range(0, 5);
          add_byte((k == 5) ? 8'h20 : 8'(9 + k), 1'b0);
        end else if (roll < 75) begin
          add_text(entity_names[k], 1'b0);
        end else if (roll < 85) begin
          add_text(entity_names[k].substr(0, $urandom_range(0, entity_names[k].len() - 2)),
                   1'b0);
        end else if (roll < 90) begin
          add_byte(8'h26, 1'b0);
        end else begin
          add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      it     = line_items.pop_back();
      it.eol = 1'b1;
      line_items.push_back(it);
    end
    pause_at = directed_count + (line_items.size() - directed_count) / 2;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = 0;
    for (int idx = 0; idx < line_items.size(); idx++) begin
      if (idx == directed_count || idx == pause_at) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_left != 0);
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      send_item(line_items[idx]);
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        roll       = $urandom_range(0, 99);
        burst_left = (roll < 20) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        gap        = (roll < 35) ? 0 : $urandom_range(1, (roll < 85) ? 4 : 20);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("[html_entity_decode_ws_collapse] OK");
    end else begin
      $display("[html_entity_decode_ws_collapse] ERROR");
    end
    $finish;
  end

endmodule
